>>> design/dstf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth fallback package
// Shared tick width, register indices, CORDIC constants and the arc-tangent table.
// ----------------------------------------------------------------------------
package dstf_pkg;
  localparam int DefTickWidth = 16;
  localparam int CordicSteps  = 16;
  localparam logic signed [19:0] CordicGain = 20'sd39797;
  localparam logic signed [19:0] PiQ16      = 20'sd205887;
  localparam logic signed [19:0] HalfPiQ16  = 20'sd102944;

  localparam logic [1:0] REG_GRACE = 2'd0;
  localparam logic [1:0] REG_TIER2 = 2'd1;
  localparam logic [1:0] REG_TIER3 = 2'd2;
  localparam logic [1:0] REG_SLEW  = 2'd3;

  function automatic logic signed [19:0] arc_of(input logic [3:0] i);
    case (i)
      4'd0:    arc_of = 20'sd51472;
      4'd1:    arc_of = 20'sd30386;
      4'd2:    arc_of = 20'sd16055;
      4'd3:    arc_of = 20'sd8150;
      4'd4:    arc_of = 20'sd4091;
      4'd5:    arc_of = 20'sd2047;
      4'd6:    arc_of = 20'sd1024;
      4'd7:    arc_of = 20'sd512;
      4'd8:    arc_of = 20'sd256;
      4'd9:    arc_of = 20'sd128;
      4'd10:   arc_of = 20'sd64;
      4'd11:   arc_of = 20'sd32;
      4'd12:   arc_of = 20'sd16;
      4'd13:   arc_of = 20'sd8;
      4'd14:   arc_of = 20'sd4;
      default: arc_of = 20'sd2;
    endcase
  endfunction
endpackage

>>> design/dstf_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth fallback sine unit
// Rotation CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module dstf_cordic
  import dstf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] pitch,
  output logic               done,
  output logic signed [17:0] sine
);
  logic signed [19:0] x, y, z;
  logic [3:0] step;
  logic busy;
  logic signed [19:0] a, dx, dy;
  logic signed [19:0] ysat;

  always_comb begin
    a = {{4{pitch[15]}}, pitch} <<< 3;
    if (a > HalfPiQ16) a = PiQ16 - a;
    else if (a < -HalfPiQ16) a = -PiQ16 - a;
    dx = y >>> step;
    dy = x >>> step;
    if (y > 20'sd65536) ysat = 20'sd65536;
    else if (y < -20'sd65536) ysat = -20'sd65536;
    else ysat = y;
  end

  assign sine = ysat[17:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !start && busy && (step == 4'(CordicSteps - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x <= CordicGain;
        y <= '0;
        z <= a;
      end else if (busy) begin
        if (!z[19]) begin
          x <= x - dx; y <= y + dy; z <= z - arc_of(step);
        end else begin
          x <= x + dx; y <= y - dy; z <= z + arc_of(step);
        end
        step <= step + 4'd1;
        if (step == 4'(CordicSteps - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

>>> design/dstf_serial_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth fallback serial multiply and divide
// Shift-add multiply and restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module dstf_serial_mac
  import dstf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               mul_start,
  input  logic [48:0]        mul_a,
  input  logic [16:0]        mul_b,
  input  logic               div_start,
  input  logic [48:0]        div_n,
  input  logic [15:0]        div_d,
  output logic               done,
  output logic [65:0]        result
);
  logic [65:0] acc;
  logic [65:0] ma;
  logic [16:0] mb;
  logic [48:0] q;
  logic [15:0] rem;
  logic [5:0]  cnt;
  logic        mode;
  logic        busy;
  logic [16:0] trial;

  assign trial = {rem, q[48]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      mode <= 1'b0;
    end else begin
      done <= !mul_start && !div_start && busy && (cnt == 6'd1);
      if (mul_start) begin
        busy <= 1'b1; mode <= 1'b0; cnt <= 6'd17;
        acc <= '0; ma <= {17'd0, mul_a}; mb <= mul_b;
      end else if (div_start) begin
        busy <= 1'b1; mode <= 1'b1; cnt <= 6'd49;
        q <= div_n; rem <= '0;
      end else if (busy) begin
        if (!mode) begin
          if (mb[0]) acc <= acc + ma;
          ma <= ma << 1;
          mb <= mb >> 1;
        end else begin
          if (trial >= {1'b0, div_d}) begin
            rem <= 16'(trial - {1'b0, div_d});
            q <= {q[47:0], 1'b1};
          end else begin
            rem <= trial[15:0];
            q <= {q[47:0], 1'b0};
          end
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign result = mode ? {17'd0, q} : acc;
endmodule

>>> design/depth_sensor_tiered_fallback_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth sensor tiered fallback
// Depth estimate with hold, dead reckoning, ceiling lock and recovery slew.
// ----------------------------------------------------------------------------
// A sensor, hold or ceiling request, or one that starts a slew, goes straight
// to the result register; a dead reckoning request first runs the CORDIC sine
// and the serial multiply, and one while slewing adds a second multiply and a
// serial divide unless it ends the slew. One request is worked on at a time;
// the next can be accepted in the cycle after the result is registered.
// Reset (rst, synchronous) restores the register defaults and clears tier state.
module depth_sensor_tiered_fallback_top
  import dstf_pkg::*;
#(
  parameter int TICK_COUNT_WIDTH = DefTickWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // reading_valid[0], sensor_depth[32:1], distance_step[48:33],
  // pitch_angle[64:49], zero fill to 72 bits
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // depth_out[31:0], virtual_flag[32], unverified_flag[33], critical_flag[34]
  output logic [39:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam logic [TICK_COUNT_WIDTH-1:0] TickMax = '1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SIN  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SMUL = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_WAIT = 3'd6;

  logic [15:0] grace_ticks, tier2_ticks, tier3_ticks, slew_ticks;
  logic [2:0]  state;
  logic        slewing, ceiling_held;
  logic [TICK_COUNT_WIDTH-1:0] ticks;
  logic [15:0] slew_count;
  logic signed [31:0] hold_d, dr_d, ceil_d, from_d, to_d;
  logic signed [15:0] in_step, in_pitch;
  logic        sl_neg;
  logic signed [31:0] res_depth;
  logic [2:0]  res_flags;
  logic        out_full;
  logic        out_load;

  logic        cs_start, cs_done;
  logic signed [17:0] sine;
  logic        mul_start, div_start, mac_done;
  logic [48:0] mul_a, div_n;
  logic [16:0] mul_b;
  logic [65:0] mac_res;
  logic        prod_neg;

  dstf_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cs_start), .pitch(in_pitch),
    .done(cs_done), .sine(sine)
  );

  dstf_serial_mac u_mac (
    .clk(clk), .rst(rst), .mul_start(mul_start), .mul_a(mul_a), .mul_b(mul_b),
    .div_start(div_start), .div_n(div_n), .div_d(slew_ticks),
    .done(mac_done), .result(mac_res)
  );

  // Dead-reckoning multiply runs on magnitudes; the sign is put back after.
  logic [16:0] step_mag, sine_mag;
  logic signed [34:0] prod_s, delta;
  logic signed [33:0] dr_sum;
  logic signed [31:0] dr_new;
  // Slew multiply and divide, also on magnitudes (truncation toward zero).
  logic signed [32:0] diff;
  logic [32:0] diff_mag;
  logic signed [49:0] quot_s;
  logic signed [33:0] slew_val;
  // Saturating next counts for the outage ticks and the slew progress.
  logic [TICK_COUNT_WIDTH-1:0] tick_inc;
  logic [15:0] slew_inc;

  always_comb begin
    step_mag = in_step[15] ? 17'(-in_step) : 17'(in_step);
    sine_mag = sine[17] ? 17'(-sine) : 17'(sine);
    prod_s = prod_neg ? -35'(mac_res[33:0]) : 35'(mac_res[33:0]);
    delta = (prod_s + 35'sd32768) >>> 16;
    dr_sum = 34'(dr_d) + 34'(delta);
    if (dr_sum > 34'sd2147483647) dr_new = 32'h7fffffff;
    else if (dr_sum < -34'sd2147483648) dr_new = 32'h80000000;
    else dr_new = dr_sum[31:0];
    diff = 33'(to_d) - 33'(from_d);
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    quot_s = sl_neg ? -50'(mac_res[48:0]) : 50'(mac_res[48:0]);
    slew_val = 34'(from_d) + quot_s[33:0];
    tick_inc = (ticks < TickMax) ? ticks + 1'b1 : ticks;
    slew_inc = (slew_count != 16'hffff) ? slew_count + 16'd1 : slew_count;
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_full;
  // The result register is loaded when it is empty or being emptied this cycle.
  assign out_load = (state == S_OUT) && (!out_full || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      grace_ticks <= 16'd10; tier2_ticks <= 16'd100;
      tier3_ticks <= 16'd500; slew_ticks <= 16'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRACE: grace_ticks <= cfg_data;
        REG_TIER2: tier2_ticks <= cfg_data;
        REG_TIER3: tier3_ticks <= cfg_data;
        REG_SLEW:  slew_ticks  <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; slewing <= 1'b0; ceiling_held <= 1'b0;
      ticks <= '0; slew_count <= '0;
      hold_d <= '0; dr_d <= '0; ceil_d <= '0; from_d <= '0; to_d <= '0;
      out_full <= 1'b0; cs_start <= 1'b0; mul_start <= 1'b0; div_start <= 1'b0;
    end else begin
      // The sine is needed while slewing and in the dead reckoning tier.
      cs_start <= (state == S_IDLE) && s_tvalid &&
                  (slewing || (!s_tdata[0] && 32'(tick_inc) >= 32'(grace_ticks) &&
                               32'(tick_inc) < 32'(tier3_ticks)));
      mul_start <= ((state == S_SIN) && cs_done) ||
                   ((state == S_MUL) && mac_done && slewing && (slew_inc < slew_ticks));
      div_start <= (state == S_SMUL) && mac_done;
      if (out_load) out_full <= 1'b1;
      else if (m_tready) out_full <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_step <= s_tdata[48:33];
            in_pitch <= s_tdata[64:49];
            if (slewing) begin
              if (s_tdata[0]) to_d <= s_tdata[32:1];
              state <= S_SIN;
            end else if (s_tdata[0]) begin
              if (32'(ticks) < 32'(tier2_ticks)) begin
                ticks <= '0; hold_d <= s_tdata[32:1]; dr_d <= s_tdata[32:1];
                ceiling_held <= 1'b0;
                res_depth <= s_tdata[32:1]; res_flags <= 3'b000;
              end else begin
                slewing <= 1'b1;
                from_d <= ceiling_held ? ceil_d : dr_d;
                res_depth <= ceiling_held ? ceil_d : dr_d;
                to_d <= s_tdata[32:1]; slew_count <= '0;
                res_flags <= 3'b001;
              end
              state <= S_OUT;
            end else begin
              ticks <= tick_inc;
              if (32'(tick_inc) < 32'(grace_ticks)) begin
                res_depth <= hold_d; res_flags <= 3'b000; state <= S_OUT;
              end else if (32'(tick_inc) < 32'(tier3_ticks)) begin
                state <= S_SIN;
              end else begin
                if (!ceiling_held) begin
                  ceiling_held <= 1'b1; ceil_d <= dr_d; res_depth <= dr_d;
                end else res_depth <= ceil_d;
                res_flags <= 3'b111; state <= S_OUT;
              end
            end
          end
        end
        S_SIN: begin
          if (cs_done) begin
            mul_a <= 49'(step_mag); mul_b <= sine_mag;
            prod_neg <= in_step[15] ^ sine[17];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mac_done) begin
            if (slewing) begin
              slew_count <= slew_inc;
              if (slew_inc >= slew_ticks) begin
                slewing <= 1'b0; ceiling_held <= 1'b0; ticks <= '0;
                hold_d <= to_d; dr_d <= to_d;
                res_depth <= to_d; res_flags <= 3'b000; state <= S_OUT;
              end else begin
                dr_d <= dr_new;
                mul_a <= {16'd0, diff_mag}; mul_b <= {1'b0, slew_inc};
                sl_neg <= diff[32];
                state <= S_SMUL;
              end
            end else begin
              dr_d <= dr_new;
              res_depth <= dr_new; res_flags <= 3'b001; state <= S_OUT;
            end
          end
        end
        S_SMUL: begin
          if (mac_done) begin
            div_n <= mac_res[48:0]; state <= S_DIV;
          end
        end
        S_DIV: begin
          if (mac_done) begin
            res_depth <= slew_val[31:0]; res_flags <= 3'b001; state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            m_tdata <= {5'd0, res_flags[2], res_flags[1], res_flags[0], res_depth};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> dv/depth_sensor_tiered_fallback_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth sensor tiered fallback testbench
// Streams navigation ticks into the block and compares each depth estimate
// with an in-bench model of the hold, dead reckoning, ceiling lock and slew
// tiers. Several register settings are visited, both sides idle at random and
// the result side is held off once for a long stretch.
// ----------------------------------------------------------------------------
module depth_sensor_tiered_fallback_top_tb;
  import dstf_pkg::*;

  typedef struct {
    logic               reading_valid;
    logic signed [31:0] sensor_depth;
    logic signed [15:0] distance_step;
    logic signed [15:0] pitch_angle;
  } tick_req_t;

  typedef struct {
    logic signed [31:0] depth;
    logic               virt;
    logic               unverified;
    logic               critical;
  } depth_res_t;

  // One row of the directed table. Where has_known is set the expected result
  // is typed in; the model is still stepped so that its state stays in line.
  typedef struct {
    tick_req_t  req;
    logic       has_known;
    depth_res_t known;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_GRACE;
  logic [15:0] cfg_data = '0;

  depth_sensor_tiered_fallback_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model state and register copies.
  longint grace_cfg, tier2_cfg, tier3_cfg, slew_cfg;
  bit     model_slewing, model_ceiling_held;
  longint idle_ticks, slew_progress;
  longint held_depth, reckoned_depth, locked_depth, slew_start, slew_target;

  depth_res_t expected_depths[$];
  int         fail_count = 0;
  int         requests_sent = 0;
  int         results_seen = 0;
  int         slew_results = 0;
  int         ceiling_results = 0;
  bit         hold_off_done = 1'b0;

  localparam longint TickMax = (64'sd1 << DefTickWidth) - 1;
  localparam int WatchdogLimit = 3000;

  // CORDIC in Q16 with the angle folded into the half circle either side of 0.
  function automatic longint cordic_sine(longint pitch_q13);
    longint arcs [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2};
    longint ang, x, y, dx, dy;
    ang = pitch_q13 * 8;
    if (ang > 102944) ang = 205887 - ang;
    else if (ang < -102944) ang = -205887 - ang;
    x = 39797;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (ang >= 0) begin
        x = x - dx; y = y + dy; ang = ang - arcs[i];
      end else begin
        x = x + dx; y = y - dy; ang = ang + arcs[i];
      end
    end
    if (y > 65536) y = 65536;
    if (y < -65536) y = -65536;
    return y;
  endfunction

  function automatic void reckon_step(longint stp, longint pitch);
    longint sum;
    sum = reckoned_depth + ((stp * cordic_sine(pitch) + 32768) >>> 16);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    reckoned_depth = sum;
  endfunction

  function automatic depth_res_t make_res(longint d, bit v, bit u, bit c);
    depth_res_t r;
    r.depth = d[31:0];
    r.virt = v;
    r.unverified = u;
    r.critical = c;
    return r;
  endfunction

  function automatic depth_res_t estimate_depth(tick_req_t rq);
    longint sd;
    sd = longint'(rq.sensor_depth);
    if (model_slewing) begin
      slew_results++;
      if (rq.reading_valid) slew_target = sd;
      reckon_step(rq.distance_step, rq.pitch_angle);
      if (slew_progress < 65535) slew_progress++;
      if (slew_progress >= slew_cfg) begin
        model_slewing = 1'b0;
        model_ceiling_held = 1'b0;
        idle_ticks = 0;
        held_depth = slew_target;
        reckoned_depth = slew_target;
        return make_res(slew_target, 0, 0, 0);
      end
      return make_res(slew_start + ((slew_target - slew_start) * slew_progress) / slew_cfg,
                      1, 0, 0);
    end
    if (rq.reading_valid) begin
      if (idle_ticks < tier2_cfg) begin
        idle_ticks = 0;
        held_depth = sd;
        reckoned_depth = sd;
        model_ceiling_held = 1'b0;
        return make_res(sd, 0, 0, 0);
      end
      model_slewing = 1'b1;
      slew_start = model_ceiling_held ? locked_depth : reckoned_depth;
      slew_target = sd;
      slew_progress = 0;
      return make_res(slew_start, 1, 0, 0);
    end
    if (idle_ticks < TickMax) idle_ticks++;
    if (idle_ticks < grace_cfg) return make_res(held_depth, 0, 0, 0);
    if (idle_ticks < tier3_cfg) begin
      reckon_step(rq.distance_step, rq.pitch_angle);
      return make_res(reckoned_depth, 1, 0, 0);
    end
    if (!model_ceiling_held) begin
      model_ceiling_held = 1'b1;
      locked_depth = reckoned_depth;
    end
    ceiling_results++;
    return make_res(locked_depth, 1, 1, 1);
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GRACE: grace_cfg = val;
      REG_TIER2: tier2_cfg = val;
      REG_TIER3: tier3_cfg = val;
      default:   slew_cfg = val;
    endcase
  endtask

  task automatic set_thresholds(logic [15:0] g, logic [15:0] t2, logic [15:0] t3,
                                logic [15:0] sl);
    write_reg(REG_GRACE, g);
    write_reg(REG_TIER2, t2);
    write_reg(REG_TIER3, t3);
    write_reg(REG_SLEW, sl);
  endtask

  // Waits until every request has answered, then lets the block settle.
  task automatic drain();
    while (expected_depths.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Offers one request, steps the model at the edge where it is taken and may
  // then idle; a typed expectation replaces the model's result.
  task automatic send_tick(tick_req_t rq, bit has_known, depth_res_t known);
    depth_res_t pred;
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, rq.pitch_angle, rq.distance_step, rq.sensor_depth,
                rq.reading_valid};
    forever begin
      @(negedge clk);
      if (s_tready) break;
    end
    @(posedge clk);
    pred = estimate_depth(rq);
    expected_depths.push_back(has_known ? known : pred);
    requests_sent++;
    if (idle_gap() != 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] pick_depth();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'sh7FFF_FFFF - $urandom_range(0, 4000);
      2: return 32'sh8000_0000 + $urandom_range(0, 4000);
      default: return $urandom_range(0, 200000) - 100000;
    endcase
  endfunction

  // Random ticks built as outages of random length ended by a reading, with
  // some plain noise mixed in.
  task automatic random_phase(int count, int max_outage);
    tick_req_t  rq;
    depth_res_t none;
    int         outage;
    none = make_res(0, 0, 0, 0);
    outage = $urandom_range(0, max_outage);
    for (int n = 0; n < count; n++) begin
      rq.distance_step = 16'($urandom);
      rq.pitch_angle = ($urandom_range(0, 99) < 85) ?
                       16'($urandom_range(0, 51472) - 25736) : 16'($urandom);
      rq.sensor_depth = pick_depth();
      if ($urandom_range(0, 9) == 0) begin
        rq.reading_valid = 1'($urandom_range(0, 1));
      end else if (outage == 0) begin
        rq.reading_valid = 1'b1;
        outage = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, max_outage);
      end else begin
        rq.reading_valid = 1'b0;
        outage--;
      end
      send_tick(rq, 1'b0, none);
    end
  endtask

  // Result side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    depth_res_t exp_r, got;
    wait (rst == 1'b0);
    forever begin
      if (!hold_off_done && results_seen >= 60) begin
        hold_off_done = 1'b1;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (idle_gap() != 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
      m_tready <= 1'b1;
      forever begin
        @(negedge clk);
        if (m_tvalid) break;
      end
      got.depth = m_tdata[31:0];
      got.virt = m_tdata[32];
      got.unverified = m_tdata[33];
      got.critical = m_tdata[34];
      @(posedge clk);
      results_seen++;
      if (expected_depths.size() == 0) begin
        $error("depth result with no request outstanding: %0d", got.depth);
        fail_count++;
      end else begin
        exp_r = expected_depths.pop_front();
        if (got.depth !== exp_r.depth) begin
          $error("depth_out: expected %0d, got %0d", exp_r.depth, got.depth);
          fail_count++;
        end
        if (got.virt !== exp_r.virt) begin
          $error("virtual_flag: expected %0b, got %0b", exp_r.virt, got.virt);
          fail_count++;
        end
        if (got.unverified !== exp_r.unverified) begin
          $error("unverified_flag: expected %0b, got %0b", exp_r.unverified,
                 got.unverified);
          fail_count++;
        end
        if (got.critical !== exp_r.critical) begin
          $error("critical_flag: expected %0b, got %0b", exp_r.critical, got.critical);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither side moves a request.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WatchdogLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  directed_row_t directed [14];

  initial begin
    grace_cfg = 10; tier2_cfg = 100; tier3_cfg = 500; slew_cfg = 50;
    model_slewing = 0; model_ceiling_held = 0; idle_ticks = 0; slew_progress = 0;
    held_depth = 0; reckoned_depth = 0; locked_depth = 0;
    slew_start = 0; slew_target = 0;

    // Extremes of depth first, then hold across the pitch extremes and out of
    // range, dead reckoning at an out-of-range pitch, and a snap back.
    directed[0]  = '{'{1, 32'sh8000_0000, 0, 0}, 1, '{32'sh8000_0000, 0, 0, 0}};
    directed[1]  = '{'{1, 32'sh7FFF_FFFF, 0, 0}, 1, '{32'sh7FFF_FFFF, 0, 0, 0}};
    directed[2]  = '{'{0, 0, 16'sh7FFF, 16'sd25736}, 1, '{32'sh7FFF_FFFF, 0, 0, 0}};
    directed[3]  = '{'{0, -1, 16'sh8000, -16'sd25736}, 1, '{32'sh7FFF_FFFF, 0, 0, 0}};
    directed[4]  = '{'{0, 5, 100, 12868}, 0, '{0, 0, 0, 0}};
    directed[5]  = '{'{0, 5, 100, -12868}, 0, '{0, 0, 0, 0}};
    directed[6]  = '{'{0, 5, 100, 16'sh7FFF}, 0, '{0, 0, 0, 0}};
    directed[7]  = '{'{0, 5, 100, 16'sh8000}, 0, '{0, 0, 0, 0}};
    directed[8]  = '{'{0, 5, 16'sh7FFF, 12868}, 0, '{0, 0, 0, 0}};
    directed[9]  = '{'{0, 5, 16'sh7FFF, 12868}, 0, '{0, 0, 0, 0}};
    directed[10] = '{'{0, 5, 16'sh7FFF, 12868}, 0, '{0, 0, 0, 0}};
    directed[11] = '{'{0, 5, 16'sh8000, 25736}, 0, '{0, 0, 0, 0}};
    directed[12] = '{'{0, 5, 16'sh8000, -25736}, 0, '{0, 0, 0, 0}};
    directed[13] = '{'{1, 1234, 0, 0}, 1, '{1234, 0, 0, 0}};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register defaults after reset.
    foreach (directed[i]) send_tick(directed[i].req, directed[i].has_known,
                                    directed[i].known);
    random_phase(90, 20);
    s_tvalid <= 1'b0;
    drain();

    // Short tiers so that dead reckoning, ceiling lock and slews come often.
    set_thresholds(2, 5, 8, 3);
    random_phase(120, 14);
    s_tvalid <= 1'b0;
    drain();

    // All thresholds at zero, including a zero-length slew.
    set_thresholds(0, 0, 0, 0);
    random_phase(90, 4);
    s_tvalid <= 1'b0;
    drain();

    // All thresholds at their largest.
    set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(70, 30);
    s_tvalid <= 1'b0;
    drain();

    // Random small settings.
    for (int p = 0; p < 3; p++) begin
      set_thresholds($urandom_range(0, 6), $urandom_range(0, 12),
                     $urandom_range(0, 20), $urandom_range(1, 8));
      random_phase(60, 25);
      s_tvalid <= 1'b0;
      drain();
    end

    $display("Ran %0d ticks through seven register settings: %0d results while slewing,",
             requests_sent, slew_results);
    $display("%0d ceiling locked, %0d results checked in all.", ceiling_results,
             results_seen);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> filelist.f
design/dstf_pkg.sv
design/dstf_cordic.sv
design/dstf_serial_mac.sv
design/depth_sensor_tiered_fallback_top.sv
dv/depth_sensor_tiered_fallback_top_tb.sv
